// ----- rtl/core/imm_pkg.sv -----
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, types and helpers of the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

  // Storage side of each square matrix
  localparam int MAX_SIZE = 64;

  // Field widths of the stream items
  localparam int KIND_W = 2;
  localparam int ROW_W  = 6;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;

  // Largest usable side: bounded by storage and by the 6-bit index fields
  localparam int SPAN   = (MAX_SIZE < (1 << ROW_W)) ? MAX_SIZE : (1 << ROW_W);
  localparam int IDX_W  = $clog2(SPAN);
  localparam int ADDR_W = 2 * IDX_W;

  // Stream data widths, padded to whole bytes
  localparam int PAYLOAD_W = 2 * ROW_W + DATA_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW    = 2'd2;

  // Memory requests from the sequencer
  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
  } mem_req_t;

  // MAC control and status
  typedef struct packed {
    logic data_vld;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

  // Effective side length: zero acts as one, large values saturate
  function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] n;
    n = s;
    if (s == '0) begin
      n = SIZE_W'(1);
    end else if (s > SIZE_W'(SPAN)) begin
      n = SIZE_W'(SPAN);
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/imm_ram.sv -----
// ----------------------------------------------------------------------------
// imm_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/imm_mac.sv -----
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate: registered product, then a wrapping 32-bit sum.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  imm_pkg::mac_ctl_t         ctl,
  input  logic [imm_pkg::DATA_W-1:0] a,
  input  logic [imm_pkg::DATA_W-1:0] b,
  output logic [imm_pkg::DATA_W-1:0] acc,
  output imm_pkg::mac_sts_t         sts
);

  logic [imm_pkg::DATA_W-1:0] prod_r;
  logic [imm_pkg::DATA_W-1:0] prod_nxt;
  logic                       prod_vld_r;
  logic [imm_pkg::DATA_W-1:0] acc_r;

  // Low word of the product is the same for signed and unsigned operands
  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.data_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.data_vld) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc      = acc_r;
  assign sts.busy = prod_vld_r;

endmodule

// ----- rtl/core/imm_seq.sv -----
// ----------------------------------------------------------------------------
// imm_seq
// Sequencer: accepts items, writes loads, walks the read addresses of a
// product row and hands each finished column to the output register.
// ----------------------------------------------------------------------------
module imm_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [imm_pkg::KIND_W-1:0]   in_tuser,
  input  logic [imm_pkg::TDATA_W-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [imm_pkg::TDATA_W-1:0]  out_tdata,
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [imm_pkg::SIZE_W-1:0]   cfg_wr_data,
  output imm_pkg::mem_req_t            mem_req,
  output imm_pkg::mac_ctl_t            mac_ctl,
  input  imm_pkg::mac_sts_t            mac_sts,
  input  logic [imm_pkg::DATA_W-1:0]   acc
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam int RW = imm_pkg::ROW_W;
  localparam int SW = imm_pkg::SIZE_W;
  localparam int IW = imm_pkg::IDX_W;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] size_r;
  logic [SW-1:0] n_eff;
  logic [SW-1:0] n_last;
  logic [RW-1:0] row_r, row_nxt;
  logic [SW-1:0] j_r, j_nxt;
  logic [SW-1:0] c_r, c_nxt;
  logic          issue_d_r;

  logic                        out_vld_r, out_vld_nxt;
  logic [RW-1:0]               out_row_r, out_row_nxt;
  logic [RW-1:0]               out_col_r, out_col_nxt;
  logic [imm_pkg::DATA_W-1:0]  out_prod_r, out_prod_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [RW-1:0]              in_row;
  logic [RW-1:0]              in_col;
  logic [imm_pkg::DATA_W-1:0] in_value;
  logic                       in_acc;
  logic                       row_ok;
  logic                       col_ok;
  logic                       emit_go;

  assign in_row   = in_tdata[RW-1:0];
  assign in_col   = in_tdata[2*RW-1:RW];
  assign in_value = in_tdata[imm_pkg::PAYLOAD_W-1:2*RW];

  assign n_eff  = imm_pkg::size_clamp(size_r);
  assign n_last = n_eff - SW'(1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign row_ok    = {1'b0, in_row} < n_eff;
  assign col_ok    = {1'b0, in_col} < n_eff;
  assign emit_go   = (state_r == ST_EMIT) && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= imm_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    j_nxt        = j_r;
    c_nxt        = c_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_prod_nxt = out_prod_r;
    out_last_nxt = out_last_r;

    mem_req.a_we    = 1'b0;
    mem_req.b_we    = 1'b0;
    mem_req.waddr   = {in_row[IW-1:0], in_col[IW-1:0]};
    mem_req.wdata   = in_value;
    mem_req.re      = 1'b0;
    mem_req.a_raddr = {row_r[IW-1:0], j_r[IW-1:0]};
    mem_req.b_raddr = {j_r[IW-1:0], c_r[IW-1:0]};

    mac_ctl.data_vld = issue_d_r;
    mac_ctl.clr      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            imm_pkg::KIND_LOAD_A: mem_req.a_we = row_ok && col_ok;
            imm_pkg::KIND_LOAD_B: mem_req.b_we = row_ok && col_ok;
            imm_pkg::KIND_ROW: begin
              if (row_ok) begin
                row_nxt     = in_row;
                j_nxt       = '0;
                c_nxt       = '0;
                mac_ctl.clr = 1'b1;
                state_nxt   = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        mem_req.re = 1'b1;
        if (j_r == n_last) begin
          j_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + SW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!issue_d_r && !mac_sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_vld_nxt  = 1'b1;
          out_row_nxt  = row_r;
          out_col_nxt  = c_r[RW-1:0];
          out_prod_nxt = acc;
          out_last_nxt = (c_r == n_last);
          mac_ctl.clr  = 1'b1;
          if (c_r == n_last) begin
            state_nxt = ST_IDLE;
          end else begin
            c_nxt     = c_r + SW'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      j_r       <= '0;
      c_r       <= '0;
      issue_d_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      j_r       <= j_nxt;
      c_r       <= c_nxt;
      issue_d_r <= mem_req.re;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_prod_r <= out_prod_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(imm_pkg::TDATA_W - imm_pkg::PAYLOAD_W){1'b0}},
                       out_prod_r, out_col_r, out_row_r};

endmodule

// ----- rtl/core/integer_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Square integer matrix product C = A x B over two on-chip matrices. A load
// transaction (kind 0 for A, 1 for B) writes one element and is
// dropped when its row or column is not below n. A row request (kind 2) gives
// the n elements of that row of C, column 0 first, the last one with tlast.
// A row request occupies the block for the whole row, longer when the output
// stalls: one shared multiply-accumulate reads one element pair per cycle
// from the two matrix memories, and each column drains the memory read,
// product and sum registers, then hands its sum to the output register.
// Input is not taken during a row request; a finished result waits in the
// output register while the next transaction is taken. Elements never loaded
// since reset read as unknown values.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [imm_pkg::KIND_W-1:0]  in_tuser,   // [1:0] kind
  input  logic [imm_pkg::TDATA_W-1:0] in_tdata,   // [5:0] row, [11:6] col, [43:12] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [imm_pkg::TDATA_W-1:0] out_tdata,  // [5:0] out_row, [11:6] out_col,
                                                  // [43:12] product
  output logic                        out_tlast,
  input  logic                        cfg_wr_en,
  input  logic [imm_pkg::SIZE_W-1:0]  cfg_wr_data // matrix_size
);

  imm_pkg::mem_req_t          mem_req;
  imm_pkg::mac_ctl_t          mac_ctl;
  imm_pkg::mac_sts_t          mac_sts;
  logic [imm_pkg::DATA_W-1:0] a_rdata;
  logic [imm_pkg::DATA_W-1:0] b_rdata;
  logic [imm_pkg::DATA_W-1:0] acc;

  imm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_req     (mem_req),
    .mac_ctl     (mac_ctl),
    .mac_sts     (mac_sts),
    .acc         (acc)
  );

  imm_ram #(
    .ADDR_W (imm_pkg::ADDR_W),
    .DATA_W (imm_pkg::DATA_W)
  ) u_ram_a (
    .clk   (clk),
    .we    (mem_req.a_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.a_raddr),
    .rdata (a_rdata)
  );

  imm_ram #(
    .ADDR_W (imm_pkg::ADDR_W),
    .DATA_W (imm_pkg::DATA_W)
  ) u_ram_b (
    .clk   (clk),
    .we    (mem_req.b_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.b_raddr),
    .rdata (b_rdata)
  );

  imm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (a_rdata),
    .b     (b_rdata),
    .acc   (acc),
    .sts   (mac_sts)
  );

endmodule

// ----- rtl/core/imm_checker.sv -----
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks of the result stream: stall hold, reset, column order.
// ----------------------------------------------------------------------------
module imm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [imm_pkg::TDATA_W-1:0] out_tdata,
  input logic                        out_tlast
);

  localparam int RW = imm_pkg::ROW_W;

  logic          mid_row_r;
  logic [RW-1:0] exp_col_r;
  logic [RW-1:0] exp_row_r;
  logic          out_acc;

  assign out_acc = out_tvalid && out_tready;

  // track position within the current product row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_row_r <= 1'b0;
    end else if (out_acc) begin
      mid_row_r <= !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      exp_col_r <= out_tdata[2*RW-1:RW] + RW'(1);
      exp_row_r <= out_tdata[RW-1:0];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !mid_row_r |-> out_tdata[2*RW-1:RW] == '0)
    else $error("product row does not start at column zero");

  a_next_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mid_row_r |->
      out_tdata[2*RW-1:RW] == exp_col_r && out_tdata[RW-1:0] == exp_row_r)
    else $error("product row column or row out of sequence");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
